// ===== rtl/lcste_pkg.sv =====
// Shared types and constants for the cache set tag engine.
// No dependencies; used by lcste_ctrl, lcste_dpath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lcste_pkg;

	// Field widths fixed by the stream format
	localparam int LINE_TAG_W = 29;
	localparam int WAY_OUT_W  = 2;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 32;
	localparam int S_TUSER_W  = 1;
	localparam int M_TUSER_W  = 2;

	// Defaults for the top-level parameters
	localparam int DEF_WAYS     = 4;
	localparam int DEF_TAG_BITS = 29;

	// Access kinds
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;  // latch the incoming word
		logic commit;   // look up, update the set and load the result register
	} lcste_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lcste_ctrl.sv =====
// Handshake controller for the cache set tag engine.
// Depends on lcste_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module lcste_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  wire                     m_tready,
	output lcste_pkg::lcste_cmd_t   cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_HELD  = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_valid_d;

	assign s_tready    = (state_q == ST_EMPTY);
	assign m_tvalid    = out_valid_q;
	assign cmd.capture = s_tvalid && (state_q == ST_EMPTY);
	assign cmd.commit  = (state_q == ST_HELD) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (cmd.capture) begin
					state_d = ST_HELD;
				end
			end
			ST_HELD: begin
				if (cmd.commit) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

	always_comb begin
		priority if (cmd.commit) begin
			out_valid_d = 1'b1;
		end else if (m_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EMPTY;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lcste_dpath.sv =====
// Datapath of the cache set tag engine: tag, valid, dirty and LRU rank state,
// the lookup and replacement logic, and the result register. Depends on lcste_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcste_dpath #(
	parameter int WAYS     = lcste_pkg::DEF_WAYS,
	parameter int TAG_BITS = lcste_pkg::DEF_TAG_BITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  lcste_pkg::lcste_cmd_t              cmd,
	input  wire                                kind,
	input  wire  [lcste_pkg::LINE_TAG_W-1:0]   line_tag,
	output logic                               hit,
	output logic [lcste_pkg::WAY_OUT_W-1:0]    way,
	output logic                               writeback,
	output logic [lcste_pkg::LINE_TAG_W-1:0]   victim_tag
);

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LTW   = lcste_pkg::LINE_TAG_W;
	localparam int WOW   = lcste_pkg::WAY_OUT_W;

	logic [TAG_BITS-1:0] tag_in;
	logic [TAG_BITS-1:0] tag_s1;
	logic                kind_s1;

	logic [TAG_BITS-1:0] tag_q  [WAYS];
	logic [WAYS-1:0]     valid_q;
	logic [WAYS-1:0]     dirty_q;
	logic [WAY_W-1:0]    rank_q [WAYS];

	logic                hit_q;
	logic [WOW-1:0]      way_q;
	logic                writeback_q;
	logic [LTW-1:0]      victim_tag_q;

	logic [WAYS-1:0]     match;
	logic                found;
	logic [WAY_W-1:0]    hit_way;
	logic                have_free;
	logic [WAY_W-1:0]    free_way;
	logic [WAY_W-1:0]    lru_way;
	logic [WAY_W-1:0]    sel_way;
	logic                wb;
	logic [TAG_BITS-1:0] vtag;
	logic [WAY_W-1:0]    old_rank;
	logic [LTW-1:0]      vtag_out;
	logic [WOW-1:0]      way_out;

	// Fit the port tag to the stored tag width
	generate
		if (TAG_BITS <= LTW) begin : g_tag_narrow
			assign tag_in   = line_tag[TAG_BITS-1:0];
			assign vtag_out = {{(LTW-TAG_BITS){1'b0}}, vtag};
		end else begin : g_tag_wide
			assign tag_in   = {{(TAG_BITS-LTW){1'b0}}, line_tag};
			assign vtag_out = vtag[LTW-1:0];
		end
		if (WAY_W >= WOW) begin : g_way_trunc
			assign way_out = sel_way[WOW-1:0];
		end else begin : g_way_ext
			assign way_out = {{(WOW-WAY_W){1'b0}}, sel_way};
		end
	endgenerate

	// Lookup: lowest matching way, lowest free way, rank-zero way
	always_comb begin
		found     = 1'b0;
		hit_way   = '0;
		have_free = 1'b0;
		free_way  = '0;
		lru_way   = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (tag_q[i] == tag_s1);
			if (match[i]) begin
				found   = 1'b1;
				hit_way = WAY_W'(i);
			end
			if (!valid_q[i]) begin
				have_free = 1'b1;
				free_way  = WAY_W'(i);
			end
			if (rank_q[i] == '0) begin
				lru_way = WAY_W'(i);
			end
		end
	end

	always_comb begin
		priority if (found) begin
			sel_way = hit_way;
		end else if (have_free) begin
			sel_way = free_way;
		end else begin
			sel_way = lru_way;
		end
		wb       = !found && !have_free && dirty_q[sel_way];
		vtag     = wb ? tag_q[sel_way] : '0;
		old_rank = rank_q[sel_way];
	end

	assign hit        = hit_q;
	assign way        = way_q;
	assign writeback  = writeback_q;
	assign victim_tag = victim_tag_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_s1  <= tag_in;
			kind_s1 <= kind;
		end
		if (cmd.commit) begin
			if (!found) begin
				tag_q[sel_way] <= tag_s1;
			end
			hit_q        <= found;
			way_q        <= way_out;
			writeback_q  <= wb;
			victim_tag_q <= vtag_out;
		end
	end

	// Valid, dirty and LRU ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < WAYS; i++) begin
				rank_q[i] <= WAY_W'(i);
			end
		end else if (cmd.commit) begin
			valid_q[sel_way] <= 1'b1;
			if (found) begin
				if (kind_s1 == lcste_pkg::KIND_WRITE) begin
					dirty_q[sel_way] <= 1'b1;
				end
			end else begin
				dirty_q[sel_way] <= (kind_s1 == lcste_pkg::KIND_WRITE);
			end
			for (int i = 0; i < WAYS; i++) begin
				if (WAY_W'(i) == sel_way) begin
					rank_q[i] <= WAY_W'(WAYS - 1);
				end else if (rank_q[i] > old_rank) begin
					rank_q[i] <= rank_q[i] - 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lru_cache_set_tag_engine_unit.sv =====
// Top level of the cache set tag engine: stream ports, controller and datapath.
// Depends on lcste_pkg, lcste_ctrl and lcste_dpath.
`timescale 1ns / 1ps
`default_nettype none

// Tag and replacement engine for one cache set of WAYS ways with write-back,
// write-allocate and true LRU replacement. Each input word carries an access
// kind (tuser bit 0: 0 read, 1 write) and a line tag. A valid matching way is a
// hit; on a miss the lowest invalid way is filled, or, with all ways valid, the
// least recently used way is replaced, and its tag is reported for writeback
// when it was dirty (victim_tag is zero otherwise). Writes set the dirty bit,
// read fills clear it, and every access makes its way most recently used.
// Each access is first captured, then committed: the commit looks up the
// set, updates valid, dirty, tag and rank state and loads the result register.
// The next word is taken while a result waits; a held word is committed once
// the result register is free or being drained. Tags are stored at TAG_BITS
// wide (the port tag is cut or zero-extended to fit); the way index on the
// port is two bits. Reset clears the valid and dirty bits and sets way i to
// LRU rank i; the tag store has no reset and is read only for valid ways.

module lru_cache_set_tag_engine_unit #(
	parameter int WAYS     = lcste_pkg::DEF_WAYS,
	parameter int TAG_BITS = lcste_pkg::DEF_TAG_BITS
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [lcste_pkg::S_TDATA_W-1:0]    s_tdata,  // [28:0] line_tag, [31:29] zero
	input  wire  [lcste_pkg::S_TUSER_W-1:0]    s_tuser,  // [0] kind
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [lcste_pkg::M_TDATA_W-1:0]    m_tdata,  // [1:0] way, [30:2] victim_tag, [31] zero
	output logic [lcste_pkg::M_TUSER_W-1:0]    m_tuser   // [0] hit, [1] writeback
);

	localparam int LTW = lcste_pkg::LINE_TAG_W;
	localparam int WOW = lcste_pkg::WAY_OUT_W;

	lcste_pkg::lcste_cmd_t cmd;

	logic           hit;
	logic [WOW-1:0] way;
	logic           writeback;
	logic [LTW-1:0] victim_tag;

	// Handshake and sequencing
	lcste_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Set state, lookup and result register
	lcste_dpath #(
		.WAYS     (WAYS),
		.TAG_BITS (TAG_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (s_tuser[0]),
		.line_tag   (s_tdata[LTW-1:0]),
		.hit        (hit),
		.way        (way),
		.writeback  (writeback),
		.victim_tag (victim_tag)
	);

	// Pack the result word; pad the top bits with zeros
	assign m_tdata = {{(lcste_pkg::M_TDATA_W - LTW - WOW){1'b0}}, victim_tag, way};
	assign m_tuser = {writeback, hit};

endmodule

`default_nettype wire

// ===== tb/sv/lru_cache_set_tag_engine_unit_check.sv =====
// Scoreboard for the cache set tag engine: watches both stream channels,
// predicts each lookup result from a private copy of the set state and compares.
// Depends on lcste_pkg for field widths and access kinds.
`timescale 1ns / 1ps

module lru_cache_set_tag_engine_unit_check #(
	parameter int WAYS = lcste_pkg::DEF_WAYS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	input  wire                              s_tready,
	input  wire [lcste_pkg::S_TDATA_W-1:0]   s_tdata,  // [28:0] line_tag, [31:29] zero
	input  wire [lcste_pkg::S_TUSER_W-1:0]   s_tuser,  // [0] kind
	input  wire                              m_tvalid,
	input  wire                              m_tready,
	input  wire [lcste_pkg::M_TDATA_W-1:0]   m_tdata,  // [1:0] way, [30:2] victim_tag, [31] zero
	input  wire [lcste_pkg::M_TUSER_W-1:0]   m_tuser,  // [0] hit, [1] writeback
	output int                               pending_results,
	output int                               mismatch_count
);

	localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LTW    = lcste_pkg::LINE_TAG_W;
	localparam int WOW    = lcste_pkg::WAY_OUT_W;

	typedef struct packed {
		logic           hit;
		logic [WOW-1:0] way;
		logic           writeback;
		logic [LTW-1:0] victim_tag;
	} set_outcome_t;

	logic              line_valid [WAYS];
	logic              line_dirty [WAYS];
	logic [LTW-1:0]    line_tag   [WAYS];
	logic [RANK_W-1:0] line_rank  [WAYS];  // 0 = least recently used

	set_outcome_t outcome_q[$];

	// Look the tag up, update the set and return the outcome of the access.
	task automatic apply_access(input logic kind, input logic [LTW-1:0] tag,
			output set_outcome_t res);
		logic [RANK_W-1:0] w;
		logic              found;
		logic              free_found;
		logic [RANK_W-1:0] old_rank;
		res        = '0;
		w          = '0;
		found      = 1'b0;
		free_found = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && line_valid[i] && line_tag[i] == tag) begin
				w     = RANK_W'(i);
				found = 1'b1;
			end
		end
		if (found) begin
			res.hit = 1'b1;
			if (kind == lcste_pkg::KIND_WRITE)
				line_dirty[w] = 1'b1;
		end else begin
			for (int i = 0; i < WAYS; i++) begin
				if (!free_found && !line_valid[i]) begin
					w          = RANK_W'(i);
					free_found = 1'b1;
				end
			end
			if (!free_found) begin
				for (int i = 0; i < WAYS; i++)
					if (line_rank[i] == '0)
						w = RANK_W'(i);
				if (line_dirty[w]) begin
					res.writeback  = 1'b1;
					res.victim_tag = line_tag[w];
				end
			end
			line_valid[w] = 1'b1;
			line_tag[w]   = tag;
			line_dirty[w] = (kind == lcste_pkg::KIND_WRITE);
		end
		// promote the way to most recent; newer ways slide down one rank
		old_rank = line_rank[w];
		for (int i = 0; i < WAYS; i++)
			if (line_rank[i] > old_rank)
				line_rank[i] = line_rank[i] - 1'b1;
		line_rank[w] = RANK_W'(WAYS - 1);
		res.way = WOW'(w);
	endtask

	task automatic flag_field(input string field, input logic [LTW-1:0] want,
			input logic [LTW-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		set_outcome_t predicted;
		set_outcome_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < WAYS; i++) begin
				line_valid[i] = 1'b0;
				line_dirty[i] = 1'b0;
				line_tag[i]   = '0;
				line_rank[i]  = RANK_W'(i);
			end
			outcome_q.delete();
			mismatch_count  = 0;
			pending_results <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_access(s_tuser[0], s_tdata[LTW-1:0], predicted);
				outcome_q.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				if (outcome_q.size() == 0) begin
					$display("%0t ns: result word with no access outstanding, actual 0x%0h/0x%0h",
						$time, m_tuser, m_tdata);
					mismatch_count++;
				end else begin
					oldest = outcome_q.pop_front();
					flag_field("hit", LTW'(oldest.hit), LTW'(m_tuser[0]));
					flag_field("way", LTW'(oldest.way), LTW'(m_tdata[WOW-1:0]));
					flag_field("writeback", LTW'(oldest.writeback), LTW'(m_tuser[1]));
					flag_field("victim_tag", oldest.victim_tag, m_tdata[WOW +: LTW]);
				end
			end
			pending_results <= outcome_q.size();
		end
	end

endmodule

// ===== tb/sv/lru_cache_set_tag_engine_unit_test.sv =====
// Top of the cache set tag engine testbench: clock, reset, access stimulus,
// result back-pressure, watchdog and verdict. Depends on lcste_pkg, the
// engine itself and lru_cache_set_tag_engine_unit_check.
`timescale 1ns / 1ps

module lru_cache_set_tag_engine_unit_test;

	localparam int LTW            = lcste_pkg::LINE_TAG_W;
	localparam int TAG_IDX_W      = $clog2(LTW);
	localparam int POOL_IDX_W     = 3;     // tag pool of eight entries
	localparam int RANDOM_WORDS   = 1300;
	localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before giving up
	localparam int SETTLE_CYCLES  = 8;     // quiet time at the end before the verdict

	// receiver behavior for one phase
	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic                            clk      = 1'b0;
	logic                            arst_n   = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [lcste_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic [lcste_pkg::S_TUSER_W-1:0] s_tuser  = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [lcste_pkg::M_TDATA_W-1:0] m_tdata;
	logic [lcste_pkg::M_TUSER_W-1:0] m_tuser;

	int pending_results;
	int mismatch_count;
	int burst_left = 0;

	always #5 clk = ~clk;

	lru_cache_set_tag_engine_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	lru_cache_set_tag_engine_unit_check tag_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.pending_results (pending_results),
		.mismatch_count  (mismatch_count)
	);

	// Offer one access word and hold it until the engine takes it. Words go out
	// in bursts; at the start of a new burst, usually drop valid for a random gap.
	task automatic offer_word(input logic kind, input logic [LTW-1:0] tag);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(lcste_pkg::S_TDATA_W - LTW){1'b0}}, tag};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop offering and wait until every predicted result has been drained.
	task automatic drain_results;
		s_tvalid  <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	// Pick a tag: plain random half the time, else one of the corner patterns.
	function automatic logic [LTW-1:0] random_tag;
		logic [LTW-1:0] one_hot;
		one_hot = '0;
		one_hot[TAG_IDX_W'($urandom_range(0, LTW - 1))] = 1'b1;
		case ($urandom_range(0, 7))
			0: random_tag = '0;
			1: random_tag = '1;
			2: random_tag = one_hot;
			3: random_tag = ~one_hot;
			default: random_tag = LTW'($urandom());
		endcase
	endfunction

	// Receiver: run phases of random length, each with its own stall pattern.
	// Phase four is always a long hold so the engine fills up and stalls its input.
	initial begin : receiver
		rx_mode_t mode;
		int       phase;
		int       span;
		phase = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			span = $urandom_range(40, 200);
			if (phase == 4)
				mode = RX_HOLD;
			else
				case ($urandom_range(0, 9))
					0, 1, 2, 3: mode = RX_ALWAYS;
					4, 5, 6:    mode = RX_RANDOM;
					7, 8:       mode = RX_SPARSE;
					default:    mode = RX_HOLD;
				endcase
			case (mode)
				RX_ALWAYS: begin
					m_tready <= 1'b1;
					repeat (span) @(posedge clk);
				end
				RX_RANDOM: begin
					repeat (span) begin
						m_tready <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
				end
				RX_SPARSE: begin
					repeat (span) begin
						m_tready <= ($urandom_range(0, 4) == 0);
						@(posedge clk);
					end
				end
				default: begin
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end
			endcase
			phase++;
		end
	end

	// Watchdog: give up once nothing moves on either channel for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		logic [LTW-1:0] tag_pool [8];
		logic [LTW-1:0] tag;
		int             pool_size;
		int             episode;
		int             episode_len;
		int             sent;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the set: fills into free ways, read and write
		// hits, then evictions of dirty and clean victims in LRU order.
		offer_word(lcste_pkg::KIND_READ,  29'h0000_0000);  // read fill, lowest tag
		offer_word(lcste_pkg::KIND_WRITE, 29'h1FFF_FFFF);  // write fill, highest tag
		offer_word(lcste_pkg::KIND_READ,  29'h0000_0000);  // read hit
		offer_word(lcste_pkg::KIND_WRITE, 29'h0000_0000);  // write hit marks dirty
		offer_word(lcste_pkg::KIND_READ,  29'h0AAA_AAAA);
		offer_word(lcste_pkg::KIND_READ,  29'h1555_5555);  // set now full
		offer_word(lcste_pkg::KIND_READ,  29'h0000_0001);  // evict dirty all-ones line
		offer_word(lcste_pkg::KIND_WRITE, 29'h1000_0000);  // evict dirty zero-tag line
		offer_word(lcste_pkg::KIND_READ,  29'h0123_4567);  // evict clean line
		offer_word(lcste_pkg::KIND_READ,  29'h1555_5555);  // read hit keeps clean
		offer_word(lcste_pkg::KIND_WRITE, 29'h0000_0001);  // write hit on read-filled line
		offer_word(lcste_pkg::KIND_READ,  29'h1765_4321);  // evict write-filled line
		offer_word(lcste_pkg::KIND_READ,  29'h1000_0000);  // bring the victim back clean
		offer_word(lcste_pkg::KIND_READ,  29'h0F0F_0F0F);
		offer_word(lcste_pkg::KIND_READ,  29'h10F0_F0F0);  // read fill over a dirty way
		offer_word(lcste_pkg::KIND_WRITE, 29'h0000_8000);
		offer_word(lcste_pkg::KIND_READ,  29'h1FFF_FFFF);
		offer_word(lcste_pkg::KIND_WRITE, 29'h0AAA_AAAA);
		offer_word(lcste_pkg::KIND_WRITE, 29'h0AAA_AAAA);  // repeated write hit
		offer_word(lcste_pkg::KIND_READ,  29'h0000_0000);
		drain_results();

		// Random part: episodes over a small pool of tags so hits, fills and
		// evictions all come up often, with a stray fresh tag now and then.
		sent    = 0;
		episode = 0;
		while (sent < RANDOM_WORDS) begin
			pool_size = $urandom_range(2, 8);
			for (int i = 0; i < 8; i++)
				tag_pool[i] = random_tag();
			episode_len = $urandom_range(20, 80);
			repeat (episode_len) begin
				if ($urandom_range(0, 9) == 0)
					tag = random_tag();
				else
					tag = tag_pool[POOL_IDX_W'($urandom_range(0, pool_size - 1))];
				offer_word(1'($urandom_range(0, 1)), tag);
				sent++;
			end
			episode++;
			if (episode == 6)
				drain_results();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
